// ===== hdl/psd_pkg.sv =====
package psd_pkg;

	localparam int SAMPLE_WIDTH  = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int FRAC_BITS     = SAMPLE_WIDTH - 3;
	localparam int STAGE_W       = 5;
	localparam int XW            = SAMPLE_WIDTH + CORDIC_STAGES + 3;
	localparam int DW            = 2 * SAMPLE_WIDTH + 4;
	localparam int NW            = DW + 14;
	localparam int TW            = NW - 2 * FRAC_BITS;

	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam longint SQRT_HALF_Q30 = 759250125;
	localparam longint ONE_C = longint'(1) << FRAC_BITS;
	localparam longint RH_C =
		(SQRT_HALF_Q30 + (longint'(1) << (32 - SAMPLE_WIDTH))) >> (33 - SAMPLE_WIDTH);

	// mode codes
	localparam logic [1:0] MOD_BPSK = 2'd0;
	localparam logic [1:0] MOD_QPSK = 2'd1;
	localparam logic [1:0] MOD_8PSK = 2'd2;

	localparam logic [31:0] ATAN_TURNS [24] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef struct packed {
		logic signed [XW-1:0]           x;
		logic signed [XW-1:0]           y;
		logic [31:0]                    z;
		logic signed [SAMPLE_WIDTH-1:0] i;
		logic signed [SAMPLE_WIDTH-1:0] q;
		logic [1:0]                     mode;
		logic                           zero;
	} cordic_t;

	// point coordinate for constellation index p, cosine or sine axis
	function automatic logic signed [SAMPLE_WIDTH-1:0] point_coord(
		logic [2:0] p, logic sin_axis);
		logic [2:0] a;
		logic signed [SAMPLE_WIDTH-1:0] r;
		a = sin_axis ? 3'(p + 3'd6) : p;
		case (a)
			3'd0: r = SAMPLE_WIDTH'(ONE_C);
			3'd1: r = SAMPLE_WIDTH'(RH_C);
			3'd2: r = '0;
			3'd3: r = -SAMPLE_WIDTH'(RH_C);
			3'd4: r = -SAMPLE_WIDTH'(ONE_C);
			3'd5: r = -SAMPLE_WIDTH'(RH_C);
			3'd6: r = '0;
			default: r = SAMPLE_WIDTH'(RH_C);
		endcase
		return r;
	endfunction

	// binary-search the phase into a linear sector, 2 or 3 bits
	function automatic logic [2:0] lin_sector(logic [31:0] z, logic m3);
		logic [31:0] alpha;
		logic [31:0] t;
		logic [31:0] refv;
		logic signed [33:0] v;
		logic [2:0] s;
		int m;
		m = m3 ? 3 : 2;
		alpha = HALF_TURN >> m;
		t = z - (HALF_TURN - alpha);
		v = {{2{t[31]}}, t};
		s = '0;
		for (int k = 0; k < 3; k++) begin
			if (k < m) begin
				refv = alpha << (m - k - 1);
				s = {s[1:0], 1'b0};
				if (v > 0) begin
					s[0] = 1'b1;
					v = v - $signed({2'b00, refv});
				end else begin
					v = v + $signed({2'b00, refv});
				end
			end
		end
		return s;
	endfunction

endpackage

// ===== hdl/psd_cordic_cell.sv =====
module psd_cordic_cell import psd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [STAGE_W-1:0] stage,
	input  logic               up_valid,
	output logic               up_ready,
	input  cordic_t            up_data,
	output logic               dn_valid,
	input  logic               dn_ready,
	output cordic_t            dn_data
);

	logic    valid_q;
	cordic_t data_q;
	cordic_t nxt;

	// one micro-rotation toward the x axis
	always_comb begin
		nxt = up_data;
		if (!up_data.y[XW-1]) begin
			nxt.x = up_data.x + (up_data.y >>> stage);
			nxt.y = up_data.y - (up_data.x >>> stage);
			nxt.z = up_data.z + ATAN_TURNS[stage];
		end else begin
			nxt.x = up_data.x - (up_data.y >>> stage);
			nxt.y = up_data.y + (up_data.x >>> stage);
			nxt.z = up_data.z - ATAN_TURNS[stage];
		end
	end

	assign up_ready = !valid_q || dn_ready;

	// advance when the next cell has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

// ===== hdl/psd_soft.sv =====
module psd_soft import psd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        up_valid,
	output logic        up_ready,
	input  cordic_t     up_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  soft_first,
	output logic [7:0]  soft_second,
	output logic [7:0]  soft_third,
	output logic [1:0]  bit_count,
	output logic [2:0]  hard_symbol
);

	localparam logic [DW-1:0] D_INIT = DW'(longint'(1) << (2 * FRAC_BITS + 3));
	localparam logic signed [NW-1:0] N_OFS = NW'(longint'(635) << (2 * FRAC_BITS));
	localparam logic signed [TW-1:0] T_SAT = TW'(1280);

	typedef logic [DW-1:0] dist_t;

	// stage 1: sector and three distances
	logic                           vld_s1;
	logic [1:0]                     mode_s1;
	logic signed [SAMPLE_WIDTH-1:0] i_s1;
	logic [2:0]                     sec_s1;
	dist_t                          dist_s1 [3];

	// stage 2: per-bit soft numerator
	logic                           vld_s2;
	logic [1:0]                     mode_s2;
	logic signed [SAMPLE_WIDTH-1:0] i_s2;
	logic [2:0]                     sec_s2;
	logic [2:0]                     pos_s2;
	logic [2:0]                     sat_s2;
	logic [10:0]                    t_s2 [3];

	// stage 3: output registers
	logic       vld_s3;
	logic [7:0] soft_s3 [3];
	logic [1:0] cnt_s3;
	logic [2:0] sym_s3;

	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3   = !vld_s3 || !out_stall;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	logic [31:0] zph;
	logic [2:0]  sec;
	logic [2:0]  pts [3];
	dist_t       dnew [3];

	// sector of the rotated phase and distances to hard point and neighbors
	always_comb begin
		logic signed [SAMPLE_WIDTH:0] ex;
		logic signed [SAMPLE_WIDTH:0] ey;
		logic signed [2*SAMPLE_WIDTH+1:0] sx;
		logic signed [2*SAMPLE_WIDTH+1:0] sy;
		zph = up_data.zero ? 32'd0 : up_data.z;
		sec = lin_sector(zph, up_data.mode != MOD_QPSK);
		pts[0] = sec;
		pts[1] = 3'(sec + 3'd7);
		pts[2] = 3'(sec + 3'd1);
		for (int p = 0; p < 3; p++) begin
			ex = (SAMPLE_WIDTH+1)'(up_data.i) - (SAMPLE_WIDTH+1)'(point_coord(pts[p], 1'b0));
			ey = (SAMPLE_WIDTH+1)'(up_data.q) - (SAMPLE_WIDTH+1)'(point_coord(pts[p], 1'b1));
			sx = ex * ex;
			sy = ey * ey;
			dnew[p] = DW'($unsigned(sx)) + DW'($unsigned(sy));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			mode_s1 <= up_data.mode;
			i_s1    <= up_data.i;
			sec_s1  <= sec;
			dist_s1 <= dnew;
		end
	end

	logic [2:0]  gry [3];
	logic [2:0]  pos_n;
	logic [2:0]  sat_n;
	logic [10:0] t_n [3];

	// per-bit minima for zero and one, then the scaled difference
	always_comb begin
		dist_t d0;
		dist_t d1;
		logic signed [NW-1:0] n;
		logic signed [TW-1:0] t;
		gry[0] = sec_s1 ^ (sec_s1 >> 1);
		gry[1] = 3'(sec_s1 + 3'd7) ^ (3'(sec_s1 + 3'd7) >> 1);
		gry[2] = 3'(sec_s1 + 3'd1) ^ (3'(sec_s1 + 3'd1) >> 1);
		for (int k = 0; k < 3; k++) begin
			d0 = D_INIT;
			d1 = D_INIT;
			if (gry[0][2-k]) d1 = dist_s1[0];
			else             d0 = dist_s1[0];
			for (int p = 1; p < 3; p++) begin
				if (gry[p][2-k]) begin
					if (dist_s1[p] < d1) d1 = dist_s1[p];
				end else begin
					if (dist_s1[p] < d0) d0 = dist_s1[p];
				end
			end
			n = ((NW'(d0) - NW'(d1)) <<< 9) + ((NW'(d0) - NW'(d1)) <<< 8) + N_OFS;
			t = TW'(n >>> (2 * FRAC_BITS));
			pos_n[k] = (n > 0);
			sat_n[k] = (t >= T_SAT);
			t_n[k]   = t[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			mode_s2 <= mode_s1;
			i_s2    <= i_s1;
			sec_s2  <= sec_s1;
			pos_s2  <= pos_n;
			sat_s2  <= sat_n;
			t_s2    <= t_n;
		end
	end

	logic [7:0] soft_n [3];
	logic [1:0] cnt_n;
	logic [2:0] sym_n;

	// final mapping per mode; divide by five through a reciprocal
	always_comb begin
		logic signed [SAMPLE_WIDTH+8:0] nb;
		logic [22:0] prod;
		logic [2:0]  g;
		g = sec_s2 ^ (sec_s2 >> 1);
		nb = (SAMPLE_WIDTH+9)'(127 <<< FRAC_BITS) - ((SAMPLE_WIDTH+9)'(i_s2) <<< 7);
		for (int k = 0; k < 3; k++) soft_n[k] = '0;
		cnt_n = '0;
		sym_n = '0;
		case (mode_s2)
			MOD_BPSK: begin
				if (nb <= 0)
					soft_n[0] = '0;
				else if ((nb >>> FRAC_BITS) > 255)
					soft_n[0] = 8'd255;
				else
					soft_n[0] = 8'(nb >>> FRAC_BITS);
				cnt_n = 2'd1;
				sym_n = {2'b00, i_s2[SAMPLE_WIDTH-1]};
			end
			MOD_QPSK: begin
				soft_n[0] = {8{g[1]}};
				soft_n[1] = {8{g[0]}};
				cnt_n = 2'd2;
				sym_n = {1'b0, g[1:0]};
			end
			MOD_8PSK: begin
				for (int k = 0; k < 3; k++) begin
					prod = 23'(t_s2[k]) * 23'd3277;
					if (!pos_s2[k])      soft_n[k] = '0;
					else if (sat_s2[k])  soft_n[k] = 8'd255;
					else                 soft_n[k] = prod[21:14];
				end
				cnt_n = 2'd3;
				sym_n = g;
			end
			default: begin
				cnt_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			soft_s3 <= soft_n;
			cnt_s3  <= cnt_n;
			sym_s3  <= sym_n;
		end
	end

	assign out_valid   = vld_s3;
	assign soft_first  = soft_s3[0];
	assign soft_second = soft_s3[1];
	assign soft_third  = soft_s3[2];
	assign bit_count   = cnt_s3;
	assign hard_symbol = sym_s3;

endmodule

// ===== hdl/psk_soft_bit_demapper.sv =====
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_phase, quadrature
// out     | output    | out_valid/out_stall| soft_first..third, bit_count, hard_symbol
// cfg     | input     | cfg_wr_en          | cfg_wr_data (modulation)
// The CORDIC cells feed psd_soft; one sample per cycle while the output is not stalled.
// The depth is set by the row of CORDIC cells, one micro-rotation per cell.
// Reset clears all valid flags and sets the mode to BPSK.
// A stall on the output backs up the pipeline stage by stage; bubbles fill.
module psk_soft_bit_demapper import psd_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] in_phase,
	input  logic signed [SAMPLE_WIDTH-1:0] quadrature,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     soft_first,
	output logic [7:0]                     soft_second,
	output logic [7:0]                     soft_third,
	output logic [1:0]                     bit_count,
	output logic [2:0]                     hard_symbol
);

	logic [1:0] mode_q;

	// hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MOD_BPSK;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	cordic_t chain_data  [CORDIC_STAGES+1];
	logic    chain_valid [CORDIC_STAGES+1];
	logic    chain_ready [CORDIC_STAGES+1];

	// fold the left half plane onto the right before the first cell
	always_comb begin
		chain_data[0].i    = in_phase;
		chain_data[0].q    = quadrature;
		chain_data[0].mode = mode_q;
		chain_data[0].zero = (in_phase == '0) && (quadrature == '0);
		if (in_phase[SAMPLE_WIDTH-1]) begin
			chain_data[0].x = -(XW'(in_phase) <<< CORDIC_STAGES);
			chain_data[0].y = -(XW'(quadrature) <<< CORDIC_STAGES);
			chain_data[0].z = HALF_TURN;
		end else begin
			chain_data[0].x = XW'(in_phase) <<< CORDIC_STAGES;
			chain_data[0].y = XW'(quadrature) <<< CORDIC_STAGES;
			chain_data[0].z = '0;
		end
	end

	assign chain_valid[0] = in_valid;
	assign in_stall       = !chain_ready[0];

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
		psd_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.stage    (STAGE_W'(k)),
			.up_valid (chain_valid[k]),
			.up_ready (chain_ready[k]),
			.up_data  (chain_data[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_ready (chain_ready[k+1]),
			.dn_data  (chain_data[k+1])
		);
	end

	psd_soft u_soft (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (chain_valid[CORDIC_STAGES]),
		.up_ready    (chain_ready[CORDIC_STAGES]),
		.up_data     (chain_data[CORDIC_STAGES]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.soft_first  (soft_first),
		.soft_second (soft_second),
		.soft_third  (soft_third),
		.bit_count   (bit_count),
		.hard_symbol (hard_symbol)
	);

	a_bpsk_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bit_count == 2'd1 |-> soft_second == 8'd0 && soft_third == 8'd0
			&& hard_symbol[2:1] == 2'b00)
		else $error("BPSK result carries unused fields");

	a_qpsk_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bit_count == 2'd2 |-> soft_third == 8'd0 && hard_symbol[2] == 1'b0
			&& (soft_first == 8'd0 || soft_first == 8'd255))
		else $error("QPSK result not hard");

	a_unused_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bit_count == 2'd0 |-> hard_symbol == 3'd0 && soft_first == 8'd0)
		else $error("unused mode result not cleared");

endmodule
